### sv/bfs_pkg.sv
package bfs_pkg;

	// Request kinds carried in the low bits of the slave-side tdata
	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_EDGE   = 2'd1;
	localparam logic [1:0] MODE_SEARCH = 2'd2;

	// Field widths of one request and one result
	localparam int MODE_W   = 2;
	localparam int VERTEX_W = 6;
	localparam int IN_W     = 16;
	localparam int OUT_W    = 8;

	// Configuration register map, register index taken from paddr[2]
	localparam int  PADDR_W              = 3;
	localparam int  NUM_VERT_W           = 7;
	localparam logic REG_IDX_NUM_VERTICES = 1'b0;
	localparam logic [NUM_VERT_W-1:0] NUM_VERT_RESET = 7'd64;

endpackage

### sv/bfs_ram.sv
module bfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/bfs_engine.sv
module bfs_engine #(
	parameter int NV = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [$clog2(NV+1)-1:0]       num_live,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bfs_pkg::IN_W-1:0]      s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bfs_pkg::OUT_W-1:0]     m_tdata,
	output logic                          m_tlast
);

	localparam int IW  = $clog2(NV);
	localparam int NCW = $clog2(NV+1);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EA_RD,
		ST_EA_WR,
		ST_EB_RD,
		ST_EB_WR,
		ST_POP,
		ST_ROW,
		ST_SCAN,
		ST_ENQ,
		ST_OUT
	} state_t;

	state_t            state_q;
	logic [NCW-1:0]    clr_cnt_q;
	logic [NCW-1:0]    clr_n_q;
	logic              clr_vld_s1;
	logic [IW-1:0]     clr_row_s1;
	logic [IW-1:0]     a_q;
	logic [IW-1:0]     b_q;
	logic [IW-1:0]     v_q;
	logic [NV-1:0]     visited_q;
	logic [NV-1:0]     pend_q;
	logic [NCW-1:0]    head_q;
	logic [NCW-1:0]    tail_q;
	logic              m_tvalid_q;
	logic [IW-1:0]     m_vertex_q;
	logic              m_last_q;

	logic [1:0]                     mode;
	logic [bfs_pkg::VERTEX_W-1:0]   va;
	logic [bfs_pkg::VERTEX_W-1:0]   vb;
	logic [bfs_pkg::VERTEX_W:0]     n_ext;
	logic                           acc_in;
	logic                           a_ok;
	logic                           b_ok;
	logic                           out_free;
	logic                           clr_rd;
	logic [NV-1:0]                  live_mask;
	logic [NV-1:0]                  clr_mask;
	logic [NV-1:0]                  one_v;
	logic [IW-1:0]                  pick;

	logic              row_we;
	logic [IW-1:0]     row_waddr;
	logic [NV-1:0]     row_wdata;
	logic              row_re;
	logic [IW-1:0]     row_raddr;
	logic [NV-1:0]     row_rdata;
	logic              fifo_we;
	logic [IW-1:0]     fifo_waddr;
	logic [IW-1:0]     fifo_wdata;
	logic              fifo_re;
	logic [IW-1:0]     fifo_rdata;

	assign mode     = s_tdata[1:0];
	assign va       = s_tdata[7:2];
	assign vb       = s_tdata[13:8];
	assign n_ext    = (bfs_pkg::VERTEX_W+1)'(num_live);
	assign a_ok     = {1'b0, va} < n_ext;
	assign b_ok     = {1'b0, vb} < n_ext;
	assign s_tready = (state_q == ST_IDLE);
	assign acc_in   = s_tvalid & s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign clr_rd   = (clr_cnt_q < clr_n_q);
	assign one_v    = NV'(1);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = bfs_pkg::OUT_W'(m_vertex_q);
	assign m_tlast  = m_last_q;

	always_comb begin
		for (int c = 0; c < NV; c++) begin
			live_mask[c] = NCW'(c) < num_live;
			clr_mask[c]  = NCW'(c) < clr_n_q;
		end
	end

	// Lowest pending neighbour first
	always_comb begin
		pick = '0;
		for (int c = NV-1; c >= 0; c--) begin
			if (pend_q[c]) begin
				pick = IW'(c);
			end
		end
	end

	always_comb begin
		row_re     = 1'b0;
		row_raddr  = a_q;
		row_we     = 1'b0;
		row_waddr  = a_q;
		row_wdata  = row_rdata;
		fifo_we    = 1'b0;
		fifo_waddr = tail_q[IW-1:0];
		fifo_wdata = pick;
		fifo_re    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				row_re    = clr_rd;
				row_raddr = clr_cnt_q[IW-1:0];
				row_we    = clr_vld_s1;
				row_waddr = clr_row_s1;
				row_wdata = row_rdata & ~clr_mask;
			end
			ST_IDLE: begin
				fifo_we    = acc_in && (mode == bfs_pkg::MODE_SEARCH) && a_ok;
				fifo_waddr = '0;
				fifo_wdata = va[IW-1:0];
			end
			ST_EA_RD: begin
				row_re = 1'b1;
			end
			ST_EA_WR: begin
				row_we    = 1'b1;
				row_wdata = row_rdata | (one_v << b_q);
			end
			ST_EB_RD: begin
				row_re    = 1'b1;
				row_raddr = b_q;
			end
			ST_EB_WR: begin
				row_we    = 1'b1;
				row_waddr = b_q;
				row_wdata = row_rdata | (one_v << a_q);
			end
			ST_POP: begin
				fifo_re = 1'b1;
			end
			ST_ROW: begin
				row_re    = 1'b1;
				row_raddr = fifo_rdata;
			end
			ST_ENQ: begin
				fifo_we = (pend_q != '0);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_cnt_q  <= '0;
			clr_n_q    <= NCW'(NV);
			clr_vld_s1 <= 1'b0;
			clr_row_s1 <= '0;
			a_q        <= '0;
			b_q        <= '0;
			v_q        <= '0;
			visited_q  <= '0;
			pend_q     <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_vertex_q <= '0;
			m_last_q   <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_vld_s1 <= clr_rd;
					clr_row_s1 <= clr_cnt_q[IW-1:0];
					if (clr_rd) begin
						clr_cnt_q <= clr_cnt_q + 1'b1;
					end else if (!clr_vld_s1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc_in) begin
						a_q <= va[IW-1:0];
						b_q <= vb[IW-1:0];
						unique case (mode)
							bfs_pkg::MODE_CLEAR: begin
								clr_cnt_q <= '0;
								clr_n_q   <= num_live;
								state_q   <= ST_CLEAR;
							end
							bfs_pkg::MODE_EDGE: begin
								if (a_ok && b_ok) begin
									state_q <= ST_EA_RD;
								end
							end
							bfs_pkg::MODE_SEARCH: begin
								if (a_ok) begin
									visited_q <= one_v << va[IW-1:0];
									head_q    <= '0;
									tail_q    <= NCW'(1);
									state_q   <= ST_POP;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_EA_RD: state_q <= ST_EA_WR;
				ST_EA_WR: state_q <= ST_EB_RD;
				ST_EB_RD: state_q <= ST_EB_WR;
				ST_EB_WR: state_q <= ST_IDLE;
				ST_POP: begin
					head_q  <= head_q + 1'b1;
					state_q <= ST_ROW;
				end
				ST_ROW: begin
					v_q     <= fifo_rdata;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					pend_q  <= row_rdata & ~visited_q & live_mask;
					state_q <= ST_ENQ;
				end
				ST_ENQ: begin
					if (pend_q != '0) begin
						pend_q[pick]    <= 1'b0;
						visited_q[pick] <= 1'b1;
						tail_q          <= tail_q + 1'b1;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_vertex_q <= v_q;
						m_last_q   <= (head_q == tail_q);
						state_q    <= (head_q == tail_q) ? ST_IDLE : ST_POP;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	bfs_ram #(
		.WIDTH (NV),
		.DEPTH (NV)
	) u_rows (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.re    (row_re),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	bfs_ram #(
		.WIDTH (IW),
		.DEPTH (NV)
	) u_fifo (
		.clk   (clk),
		.we    (fifo_we),
		.waddr (fifo_waddr),
		.wdata (fifo_wdata),
		.re    (fifo_re),
		.raddr (head_q[IW-1:0]),
		.rdata (fifo_rdata)
	);

	// Each vertex marked visited has exactly one FIFO slot
	a_visited_matches_tail: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(visited_q) == tail_q)
		else $error("visited count and FIFO tail disagree");

	a_head_not_past_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("FIFO head ran past tail");

	a_pending_unvisited: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q & visited_q) == '0)
		else $error("pending neighbour already visited");

	a_idle_fifo_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (head_q == tail_q))
		else $error("search ended with FIFO not drained");

	a_last_ends_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free && head_q == tail_q) |=> (state_q == ST_IDLE && m_tlast))
		else $error("final vertex not marked last");

endmodule

### sv/bfs_adjacency_matrix_top.sv
// Clear request for n vertices in use: one row rewritten per cycle.
// Add-edge request: two read-modify-write passes on the matrix row memory.
// Search request: for each visited vertex, the FIFO read, the row read, then one FIFO write
// per cycle for its newly found neighbours; the next request waits for the end.
// After reset every matrix row (MAX_VERT capped at 64 rows) is swept to zero,
// with s_tready low; configuration writes are taken throughout.
module bfs_adjacency_matrix_top #(
	parameter int MAX_VERT = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// APB-style configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bfs_pkg::PADDR_W-1:0]      paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	// request stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bfs_pkg::IN_W-1:0]         s_tdata,   // mode[1:0], vertex_a[7:2], vertex_b[13:8]
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bfs_pkg::OUT_W-1:0]        m_tdata,   // vertex[5:0]
	output logic                             m_tlast
);

	// Vertex fields are six bits wide, so never more than 64 rows
	localparam int NV  = (MAX_VERT < 64) ? MAX_VERT : 64;
	localparam int NCW = $clog2(NV+1);

	logic [bfs_pkg::NUM_VERT_W-1:0] num_vertices_q;
	logic [NCW-1:0]                 num_live;
	logic                           reg_sel;
	logic                           cfg_wr;

	// Zero wait states on every access
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == bfs_pkg::REG_IDX_NUM_VERTICES);
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign prdata  = reg_sel ? 32'(num_vertices_q) : '0;

	// Hold the register; only the seven low bits of the write data are kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vertices_q <= bfs_pkg::NUM_VERT_RESET;
		end else if (cfg_wr && reg_sel) begin
			num_vertices_q <= pwdata[bfs_pkg::NUM_VERT_W-1:0];
		end
	end

	// Limit the vertex count to the rows that exist
	assign num_live = (num_vertices_q > bfs_pkg::NUM_VERT_W'(NV)) ? NCW'(NV)
		: num_vertices_q[NCW-1:0];

	bfs_engine #(
		.NV (NV)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.num_live (num_live),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
